@@ hdl/q17_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package q17_pkg;

    // Operation codes carried in the action field
    localparam logic [3:0] ACT_ADD        = 4'd0;
    localparam logic [3:0] ACT_SUB        = 4'd1;
    localparam logic [3:0] ACT_NEG        = 4'd2;
    localparam logic [3:0] ACT_MUL        = 4'd3;
    localparam logic [3:0] ACT_DIV        = 4'd4;
    localparam logic [3:0] ACT_SQRT       = 4'd5;
    localparam logic [3:0] ACT_TO_INT     = 4'd6;
    localparam logic [3:0] ACT_FROM_INT   = 4'd7;
    localparam logic [3:0] ACT_TO_FLOAT   = 4'd8;
    localparam logic [3:0] ACT_FROM_FLOAT = 4'd9;

    localparam int FRAC_BITS    = 17;
    localparam int DIV_STEPS    = 32;
    localparam int NEWTON_ITERS = 5;

    localparam logic [31:0] MAG_MAX  = 32'h7fff_ffff;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [31:0] ROOT_SEED = 32'd1255;

    // Float conversion: exponent that leaves the mantissa unshifted, and
    // exponent field of a fixed value whose leading one sits at bit 31
    localparam logic [7:0] FLT_UNIT_EXP = 8'd133;
    localparam logic [7:0] FLT_TOP_EXP  = 8'd141;

    // Per-transaction sideband carried down the pipeline
    typedef struct packed {
        logic [3:0]  act;
        logic [31:0] a;
        logic [31:0] amag;
        logic [31:0] bmag;
        logic        bzero;
        logic        sgn;
        logic        sat;
        logic [31:0] res;
        logic [31:0] g;
        logic [31:0] dq;
    } item_t;

    // Count leading zeros of a 32-bit word (32 for zero)
    function automatic logic [5:0] clz32(input logic [31:0] x);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ hdl/q17_fixed_point_alu_unit.sv @@
// Q14.17 fixed-point arithmetic unit, fully pipelined.
//
// Input stream (s_): one transaction carries action, operand_a and operand_b
// in s_tdata. Output stream (m_): one transaction per input with the 32-bit
// result in m_tdata, always in input order.
//
// From input to output transaction the path runs through three front
// stages (magnitudes, multiply, saturation and to-float), then five Newton blocks of 33
// stages each (32 one-bit division stages plus an update stage), then the
// output register. Every operation takes the same path, so one transaction
// is accepted per cycle and results stream out one per cycle while m_tready does not stall the output.
//
// Reset (aresetn low, synchronous) empties the pipeline; payload is not
// cleared. When m_tready is low while a result is held, the whole pipeline
// freezes and s_tready drops in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module q17_fixed_point_alu_unit
    import q17_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // action[3:0], operand_a[35:4], operand_b[67:36]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // result[31:0]
);

    logic ce;

    // Advance whenever the output register is empty or being drained
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    logic  f_valid;
    item_t f_item;

    q17_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .in_act    (s_tdata[3:0]),
        .in_a      (s_tdata[35:4]),
        .in_b      (s_tdata[67:36]),
        .out_valid (f_valid),
        .out_item  (f_item)
    );

    // Newton blocks; the quotient of the first one also serves as the fixed-point divide
    logic        blk_v_in   [NEWTON_ITERS];
    item_t       blk_item_in[NEWTON_ITERS];
    logic        blk_v_out  [NEWTON_ITERS];
    item_t       blk_item_out[NEWTON_ITERS];
    logic [31:0] blk_quo    [NEWTON_ITERS];
    logic        upd_v_reg  [NEWTON_ITERS];
    item_t       upd_item_reg[NEWTON_ITERS];
    item_t       upd_item_next[NEWTON_ITERS];

    genvar k;
    generate
        for (k = 0; k < NEWTON_ITERS; k++) begin : g_blk
            logic        is_div;
            logic [31:0] rem0, lo0, den0;

            if (k == 0) begin : g_first
                assign blk_v_in[k]    = f_valid;
                assign blk_item_in[k] = f_item;
            end else begin : g_rest
                assign blk_v_in[k]    = upd_v_reg[k-1];
                assign blk_item_in[k] = upd_item_reg[k-1];
            end

            // Divide sets up (|a| << 17) / |b|, root sets up x / g with x = a << 1
            assign is_div = (blk_item_in[k].act == ACT_DIV);
            assign rem0   = is_div ? (blk_item_in[k].amag >> 15) : '0;
            assign lo0    = is_div ? {blk_item_in[k].amag[14:0], 17'd0}
                                   : {blk_item_in[k].a[30:0], 1'b0};
            assign den0   = is_div ? blk_item_in[k].bmag : blk_item_in[k].g;

            q17_divpipe u_div (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ce        (ce),
                .in_valid  (blk_v_in[k]),
                .in_rem    (rem0),
                .in_lo     (lo0),
                .in_den    (den0),
                .in_item   (blk_item_in[k]),
                .out_valid (blk_v_out[k]),
                .out_quo   (blk_quo[k]),
                .out_item  (blk_item_out[k])
            );

            // Update the guess: g = (g + q) / 2; keep the divide quotient
            always_comb begin
                upd_item_next[k]   = blk_item_out[k];
                upd_item_next[k].g = 32'(({1'b0, blk_item_out[k].g}
                                          + {1'b0, blk_quo[k]}) >> 1);
                if (k == 0) begin
                    upd_item_next[k].dq = blk_quo[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    upd_v_reg[k] <= 1'b0;
                end else if (ce) begin
                    upd_v_reg[k] <= blk_v_out[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    upd_item_reg[k] <= upd_item_next[k];
                end
            end
        end
    endgenerate

    // Output stage: resolve divide and root, select the result
    item_t       fin;
    logic [31:0] div_mag;
    logic [31:0] m_tdata_next;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    assign fin = upd_item_reg[NEWTON_ITERS-1];

    always_comb begin
        div_mag = (fin.sat || fin.dq[31]) ? MAG_MAX : fin.dq;
        case (fin.act)
            ACT_DIV: begin
                if (fin.bzero) begin
                    m_tdata_next = fin.a[31] ? SIGN_BIT : MAG_MAX;
                end else begin
                    m_tdata_next = fin.sgn ? 32'(32'd0 - div_mag) : div_mag;
                end
            end
            ACT_SQRT: begin
                if (fin.a[31] || fin.a == 32'd0) begin
                    m_tdata_next = fin.a;
                end else begin
                    m_tdata_next = fin.g << 8;
                end
            end
            default: m_tdata_next = fin.res;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= upd_v_reg[NEWTON_ITERS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A held result must freeze the input side
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // The root guess never collapses to zero after the first update
    a_guess_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd_v_reg[0] && upd_item_reg[0].act == ACT_SQRT) |-> (upd_item_reg[0].g != 32'd0))
        else $error("root guess reached zero");

endmodule

`default_nettype wire

@@ hdl/q17_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module q17_front
    import q17_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        ce,
    input  wire logic        in_valid,
    input  wire logic [3:0]  in_act,
    input  wire logic [31:0] in_a,
    input  wire logic [31:0] in_b,
    output logic             out_valid,
    output item_t            out_item
);

    // Stage 1: capture operands and their magnitudes
    logic        v1_reg;
    logic [3:0]  act1_reg;
    logic [31:0] a1_reg, b1_reg, amag1_reg, bmag1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            act1_reg  <= in_act;
            a1_reg    <= in_a;
            b1_reg    <= in_b;
            amag1_reg <= in_a[31] ? 32'(32'd0 - in_a) : in_a;
            bmag1_reg <= in_b[31] ? 32'(32'd0 - in_b) : in_b;
        end
    end

    // Stage 2: product, leading zeros and the short operations
    logic        v2_reg;
    logic [3:0]  act2_reg;
    logic [31:0] a2_reg, amag2_reg, bmag2_reg, res2_reg;
    logic [63:0] prod2_reg;
    logic [5:0]  lz2_reg;
    logic        sgn2_reg, sat2_reg, bzero2_reg;

    logic [31:0] res2_next;
    logic [31:0] toint_mag;
    logic [7:0]  fexp, fsh;
    logic [31:0] fman, fmag;

    always_comb begin
        // from-float: shift the mantissa by the distance to the unit exponent
        fexp = a1_reg[30:23];
        fman = {8'd0, 1'b1, a1_reg[22:0]};
        fmag = '0;
        fsh  = '0;
        if (fexp >= FLT_UNIT_EXP) begin
            fsh  = 8'(fexp - FLT_UNIT_EXP);
            fmag = (fsh < 8'd32) ? (fman << fsh[4:0]) : '0;
        end else begin
            fsh  = 8'(FLT_UNIT_EXP - fexp);
            fmag = (fsh < 8'd32) ? (fman >> fsh[4:0]) : '0;
        end
        toint_mag = amag1_reg >> FRAC_BITS;

        case (act1_reg)
            ACT_ADD:      res2_next = 32'(a1_reg + b1_reg);
            ACT_SUB:      res2_next = 32'(a1_reg - b1_reg);
            ACT_NEG:      res2_next = 32'(32'd0 - a1_reg);
            ACT_TO_INT:   res2_next = a1_reg[31] ? 32'(32'd0 - toint_mag) : toint_mag;
            ACT_FROM_INT: res2_next = a1_reg << FRAC_BITS;
            ACT_FROM_FLOAT: begin
                if (a1_reg[30:0] == 31'd0) begin
                    res2_next = '0;
                end else begin
                    res2_next = a1_reg[31] ? 32'(32'd0 - fmag) : fmag;
                end
            end
            default:      res2_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            act2_reg   <= act1_reg;
            a2_reg     <= a1_reg;
            amag2_reg  <= amag1_reg;
            bmag2_reg  <= bmag1_reg;
            res2_reg   <= res2_next;
            prod2_reg  <= {32'd0, amag1_reg} * {32'd0, bmag1_reg};
            lz2_reg    <= clz32(amag1_reg);
            sgn2_reg   <= a1_reg[31] ^ b1_reg[31];
            // quotient of 2^32 or more: high dividend word already not below divisor
            sat2_reg   <= (amag1_reg >> 15) >= bmag1_reg;
            bzero2_reg <= (b1_reg == 32'd0);
        end
    end

    // Stage 3: finish multiply and to-float
    logic        v3_reg;
    item_t       item3_reg;
    item_t       item3_next;
    logic [46:0] mul_t;
    logic [31:0] mul_mag, norm;

    always_comb begin
        mul_t   = prod2_reg[63:FRAC_BITS];
        mul_mag = (mul_t >= 47'h8000_0000) ? MAG_MAX : mul_t[31:0];
        norm    = amag2_reg << lz2_reg;

        item3_next       = '0;
        item3_next.act   = act2_reg;
        item3_next.a     = a2_reg;
        item3_next.amag  = amag2_reg;
        item3_next.bmag  = bmag2_reg;
        item3_next.bzero = bzero2_reg;
        item3_next.sgn   = sgn2_reg;
        item3_next.sat   = sat2_reg;
        item3_next.g     = ROOT_SEED;
        case (act2_reg)
            ACT_MUL: item3_next.res = sgn2_reg ? 32'(32'd0 - mul_mag) : mul_mag;
            ACT_TO_FLOAT: begin
                if (a2_reg == 32'd0) begin
                    item3_next.res = '0;
                end else begin
                    item3_next.res = {a2_reg[31], 8'(FLT_TOP_EXP - {2'b00, lz2_reg}),
                                      norm[30:8]};
                end
            end
            default: item3_next.res = res2_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ce) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            item3_reg <= item3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

`default_nettype wire

@@ hdl/q17_divpipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

module q17_divpipe
    import q17_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        ce,
    input  wire logic        in_valid,
    input  wire logic [31:0] in_rem,
    input  wire logic [31:0] in_lo,
    input  wire logic [31:0] in_den,
    input  wire item_t       in_item,
    output logic             out_valid,
    output logic [31:0]      out_quo,
    output item_t            out_item
);

    // One quotient bit per stage: restoring division of {rem, lo} by den
    logic        v_in   [DIV_STEPS];
    logic [31:0] rem_in [DIV_STEPS];
    logic [31:0] lo_in  [DIV_STEPS];
    logic [31:0] den_in [DIV_STEPS];
    logic [31:0] quo_in [DIV_STEPS];
    item_t       item_in[DIV_STEPS];

    logic        v_reg   [DIV_STEPS];
    logic [31:0] rem_reg [DIV_STEPS];
    logic [31:0] lo_reg  [DIV_STEPS];
    logic [31:0] den_reg [DIV_STEPS];
    logic [31:0] quo_reg [DIV_STEPS];
    item_t       item_reg[DIV_STEPS];

    logic [31:0] rem_next[DIV_STEPS];
    logic [31:0] quo_next[DIV_STEPS];

    genvar i;
    generate
        for (i = 0; i < DIV_STEPS; i++) begin : g_step
            logic [32:0] trial;
            logic        ge;

            if (i == 0) begin : g_first
                assign v_in[i]    = in_valid;
                assign rem_in[i]  = in_rem;
                assign lo_in[i]   = in_lo;
                assign den_in[i]  = in_den;
                assign quo_in[i]  = '0;
                assign item_in[i] = in_item;
            end else begin : g_rest
                assign v_in[i]    = v_reg[i-1];
                assign rem_in[i]  = rem_reg[i-1];
                assign lo_in[i]   = lo_reg[i-1];
                assign den_in[i]  = den_reg[i-1];
                assign quo_in[i]  = quo_reg[i-1];
                assign item_in[i] = item_reg[i-1];
            end

            // Shift in the next dividend bit, subtract if it fits
            assign trial       = {rem_in[i], lo_in[i][31]};
            assign ge          = trial >= {1'b0, den_in[i]};
            assign rem_next[i] = ge ? 32'(trial - {1'b0, den_in[i]}) : trial[31:0];
            assign quo_next[i] = {quo_in[i][30:0], ge};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (ce) begin
                    v_reg[i] <= v_in[i];
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[i]  <= rem_next[i];
                    lo_reg[i]   <= {lo_in[i][30:0], 1'b0};
                    den_reg[i]  <= den_in[i];
                    quo_reg[i]  <= quo_next[i];
                    item_reg[i] <= item_in[i];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[DIV_STEPS-1];
    assign out_quo   = quo_reg[DIV_STEPS-1];
    assign out_item  = item_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

@@ tb/q17_fixed_point_alu_unit_tb.sv @@
`timescale 1ns / 1ps

module q17_fixed_point_alu_unit_tb;
    import q17_pkg::*;

    localparam int LATENCY     = 169;
    localparam int STALL_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // action[3:0], operand_a[35:4], operand_b[67:36]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // result[31:0]

    logic [31:0] results_due[$];
    int          mismatch_count;
    int          result_count;
    int          item_count;
    int          idle_cycles;
    bit          calm_mode;

    q17_fixed_point_alu_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sign-magnitude helpers for the arithmetic model
    function automatic logic [31:0] mag_of(input logic [31:0] x);
        return x[31] ? 32'd0 - x : x;
    endfunction

    function automatic int lead_zeros(input logic [31:0] x);
        int n;
        n = 0;
        while (n < 32 && !x[31 - n]) n++;
        return n;
    endfunction

    function automatic logic [31:0] newton_sqrt(input logic [31:0] x);
        logic [31:0] g;
        logic [31:0] q;
        g = ROOT_SEED;
        if (x < 32'd2) return x;
        for (int i = 0; i < 5; i++) begin
            q = (g != 0) ? x / g : 32'd0;
            g = 32'(({32'd0, g} + {32'd0, q}) >> 1);
        end
        return g;
    endfunction

    // Compute the ALU result for one transaction
    function automatic logic [31:0] alu_result(input logic [3:0] act,
                                               input logic [31:0] a,
                                               input logic [31:0] b);
        logic [63:0] wide;
        logic [31:0] r;
        logic [31:0] m;
        int          e;
        logic [7:0]  ex;
        case (act)
            ACT_ADD:      r = a + b;
            ACT_SUB:      r = a - b;
            ACT_NEG:      r = 32'd0 - a;
            ACT_MUL: begin
                wide = (64'(mag_of(a)) * 64'(mag_of(b))) >> FRAC_BITS;
                r = (wide >= 64'h8000_0000) ? MAG_MAX : wide[31:0];
                if (a[31] ^ b[31]) r = 32'd0 - r;
            end
            ACT_DIV: begin
                if (b == 0) begin
                    r = a[31] ? SIGN_BIT : MAG_MAX;
                end else begin
                    wide = (64'(mag_of(a)) << FRAC_BITS) / 64'(mag_of(b));
                    r = (wide >= 64'h8000_0000) ? MAG_MAX : wide[31:0];
                    if (a[31] ^ b[31]) r = 32'd0 - r;
                end
            end
            ACT_SQRT:     r = (a[31] || a == 0) ? a : newton_sqrt(a << 1) << 8;
            ACT_TO_INT: begin
                r = mag_of(a) >> FRAC_BITS;
                if (a[31]) r = 32'd0 - r;
            end
            ACT_FROM_INT: r = a << FRAC_BITS;
            ACT_TO_FLOAT: begin
                if (a == 0) begin
                    r = 32'd0;
                end else begin
                    m = mag_of(a);
                    e = 46 - lead_zeros(m);
                    if (e <= 38) m = m << (38 - e);
                    else m = m >> (e - 38);
                    r = {a[31], 8'(e - 32 + 127), m[22:0]};
                end
            end
            ACT_FROM_FLOAT: begin
                if (a[30:0] == 0) begin
                    r = 32'd0;
                end else begin
                    ex = a[30:23];
                    m = {9'd1, a[22:0]};
                    if (ex >= FLT_UNIT_EXP)
                        m = (ex - FLT_UNIT_EXP < 32) ? m << (ex - FLT_UNIT_EXP) : 32'd0;
                    else
                        m = (FLT_UNIT_EXP - ex < 32) ? m >> (FLT_UNIT_EXP - ex) : 32'd0;
                    r = a[31] ? 32'd0 - m : m;
                end
            end
            default:      r = 32'd0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Send one transaction, idling at random beforehand; valid stays high
    // until the next idle cycle or drain
    task automatic send_op(input logic [3:0] act, input logic [31:0] a,
                           input logic [31:0] b);
        while (!calm_mode && $urandom_range(99, 0) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, b, a, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        results_due.push_back(alu_result(act, a, b));
        item_count++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5, 0))
            0: return {$urandom_range(1, 0) ? 15'h7fff : 15'h0, 17'($urandom)};
            1: return 32'($urandom_range(8, 0)) << $urandom_range(31, 0);
            2: return 32'd0 - (32'($urandom_range(8, 0)) << $urandom_range(31, 0));
            default: return $urandom;
        endcase
    endfunction

    // Receive side: random backpressure and in-order comparison
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm_mode ? 1'b1 : ($urandom_range(99, 0) >= 15);
            if (m_tvalid && m_tready) begin
                result_count++;
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    if (m_tdata !== results_due[0])
                        report_mismatch($sformatf("result got %h expected %h",
                                                  m_tdata, results_due[0]));
                    void'(results_due.pop_front());
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_edge_values();
        logic [31:0] ext[6];
        ext = '{32'h0, 32'h1, 32'hffff_ffff, MAG_MAX, SIGN_BIT, 32'h0002_0000};
        for (int op = 0; op < 10; op++)
            send_op(4'(op), ext[op % 6], ext[(op + 2) % 6]);
        send_op(ACT_DIV, 32'h0001_0000, 32'h0);
        send_op(ACT_DIV, SIGN_BIT, 32'h0);
        send_op(ACT_MUL, SIGN_BIT, SIGN_BIT);
        send_op(ACT_SQRT, 32'hffff_0000, 32'h0);
        send_op(ACT_SQRT, 32'h0, 32'h0);
        send_op(ACT_TO_INT, SIGN_BIT, 32'h0);
        send_op(ACT_TO_FLOAT, 32'h0, 32'h0);
        send_op(ACT_FROM_FLOAT, SIGN_BIT, 32'h0);
        send_op(ACT_FROM_FLOAT, 32'h7f80_0000, 32'h0);
        send_op(ACT_FROM_FLOAT, 32'h0080_0001, 32'h0);
        send_op(ACT_FROM_FLOAT, 32'h4f00_0000, 32'h0);
        send_op(4'd10, 32'h1234_5678, 32'h0);
        send_op(4'd15, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    task automatic test_pause_to_empty();
        drain_results();
        repeat (8) send_op(4'($urandom_range(9, 0)), rand_word(), rand_word());
    endtask

    task automatic test_random_ops(input int count, input bit calm);
        calm_mode = calm;
        for (int i = 0; i < count; i++)
            send_op(($urandom_range(19, 0) == 0) ? 4'($urandom_range(15, 10))
                                                 : 4'($urandom_range(9, 0)),
                    rand_word(), rand_word());
        calm_mode = 1'b0;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        mismatch_count = 0;
        result_count   = 0;
        item_count     = 0;
        idle_cycles    = 0;
        calm_mode      = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edge_values();
        test_pause_to_empty();
        test_random_ops(700, 1'b0);
        test_random_ops(200, 1'b1);
        test_random_ops(180, 1'b0);

        // Wait out the pipeline, then let trailing cycles pass
        drain_results();
        repeat (LATENCY + 10) @(posedge aclk);

        $display("Sent %0d transactions over all 16 action codes, checked %0d results",
                 item_count, result_count);
        $display("with random stalls on both sides, a calm stretch and a full drain.");
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
